FILE: rtl/hba_pkg.sv
// shared widths, codes and sizes for the histogram bin accumulator
package hba_pkg;

  localparam int BIN_COUNT  = 256;
  localparam int EDGE_DEPTH = BIN_COUNT + 1;
  localparam int EDGE_AW    = $clog2(EDGE_DEPTH);
  localparam int BIN_W      = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int CNT_W      = $clog2(BIN_COUNT + 2);
  localparam int SB_W       = CNT_W + 1;
  localparam int FIRST_MID  = EDGE_DEPTH / 2;

  localparam int KIND_W   = 3;
  localparam int DATA_W   = 32;
  localparam int SLOT_W   = 9;
  localparam int IDX_W    = 10;
  localparam int SUM_W    = 48;
  localparam int STATUS_W = 2;
  localparam int MODE_W   = 2;

  localparam logic [KIND_W-1:0] K_LOAD_EDGE  = 3'd0;
  localparam logic [KIND_W-1:0] K_ADD_SAMPLE = 3'd1;
  localparam logic [KIND_W-1:0] K_ADD_TO_BIN = 3'd2;
  localparam logic [KIND_W-1:0] K_READ_BIN   = 3'd3;
  localparam logic [KIND_W-1:0] K_CLEAR_ALL  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SQUEEZED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ERROR    = 2'd3;

  localparam logic [MODE_W-1:0] MODE_IGNORE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SQUEEZE = 2'd1;

endpackage

FILE: rtl/hba_ram.sv
// generic single-write, single-read ram with registered read data
module hba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/hba_sat_add.sv
// saturating add of a q16.16 weight onto a 48-bit q32.16 bin sum
module hba_sat_add (
  input  logic signed [hba_pkg::SUM_W-1:0]  acc,
  input  logic signed [hba_pkg::DATA_W-1:0] addend,
  output logic signed [hba_pkg::SUM_W-1:0]  result
);
  import hba_pkg::*;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  logic signed [SUM_W:0] wide;

  assign wide = (SUM_W+1)'(acc) + (SUM_W+1)'(addend);

  always_comb begin
    if (wide[SUM_W] != wide[SUM_W-1]) begin
      result = wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      result = wide[SUM_W-1:0];
    end
  end

endmodule

FILE: rtl/histogram_bin_accumulator.sv
// weighted histogram: edge store, binary search sequencer and bin sum update
//
//  port group        dir  meaning
//  start/busy        in/out command transfer when start is high and busy is low
//  kind..weight      in   command payload
//  cfg_write/data    in   out_of_range_mode write, taken on any edge with cfg_write
//  done              out  one-cycle result strobe
//  bin_index..status out  result payload, valid while done is high
//
// add_sample in range: dispatch, two range reads of the end edges, 8 or 9 search reads
// through the one edge ram port, bin decision, sum read-modify-write; below range it
// stops after the first range read, above range after the second; squeezed ones still
// do the sum step. other commands end after dispatch or the sum step; busy drops with
// done, so the next command can transfer in the done cycle. reset and clear_all empty
// the sum store at once through per-bin valid bits. the receiver cannot stall results.
module histogram_bin_accumulator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [hba_pkg::KIND_W-1:0]            kind,
  input  logic signed [hba_pkg::DATA_W-1:0]     sample_or_edge,
  input  logic [hba_pkg::SLOT_W-1:0]            slot_index,
  input  logic signed [hba_pkg::DATA_W-1:0]     weight,
  input  logic                                  cfg_write,
  input  logic [hba_pkg::MODE_W-1:0]            cfg_data,
  output logic                                  done,
  output logic signed [hba_pkg::IDX_W-1:0]      bin_index,
  output logic signed [hba_pkg::SUM_W-1:0]      bin_sum,
  output logic [hba_pkg::STATUS_W-1:0]          status
);
  import hba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_E0,
    S_EN,
    S_SRCH,
    S_BIN,
    S_SUM
  } state_t;

  state_t state;

  logic [KIND_W-1:0]        kind_q;
  logic signed [DATA_W-1:0] x_q;
  logic [SLOT_W-1:0]        slot_q;
  logic signed [DATA_W-1:0] w_q;
  logic [MODE_W-1:0]        out_of_range_mode;

  logic [CNT_W-1:0]         first;
  logic [CNT_W-1:0]         count;
  logic [EDGE_AW-1:0]       mid;
  logic signed [SB_W-1:0]   sbin;
  logic [BIN_W-1:0]         bin_q;
  logic                     op_add;
  logic                     squeezed;
  logic [BIN_COUNT-1:0]     valid;

  // ram ports
  logic                     edge_we;
  logic [EDGE_AW-1:0]       edge_raddr;
  logic [DATA_W-1:0]        edge_rdata;
  logic                     sum_we;
  logic [BIN_W-1:0]         sum_raddr;
  logic [SUM_W-1:0]         sum_rdata;
  logic signed [SUM_W-1:0]  sum_cur;
  logic signed [SUM_W-1:0]  sum_new;

  // search step
  logic [CNT_W-1:0]         step;
  logic                     ge;
  logic [CNT_W-1:0]         first_next;
  logic [CNT_W-1:0]         count_next;

  // bin decision
  logic                     below;
  logic                     above;
  logic                     slot_edge_ok;
  logic                     slot_bin_ok;

  assign busy = (state != S_IDLE);

  assign slot_edge_ok = (32'(slot_q) <= BIN_COUNT);
  assign slot_bin_ok  = (32'(slot_q) < BIN_COUNT);

  assign step = count >> 1;
  assign ge   = !(x_q < $signed(edge_rdata));

  always_comb begin
    if (ge) begin
      first_next = CNT_W'(mid) + CNT_W'(1);
      count_next = count - step - CNT_W'(1);
    end else begin
      first_next = first;
      count_next = step;
    end
  end

  assign below = sbin[SB_W-1];
  assign above = !below && (32'($unsigned(sbin)) >= BIN_COUNT);

  // entries not written since reset or clear_all read as zero
  assign sum_cur = valid[bin_q] ? $signed(sum_rdata) : '0;

  hba_sat_add u_sat_add (
    .acc    (sum_cur),
    .addend (w_q),
    .result (sum_new)
  );

  // read address steering; hold the last address by default
  always_comb begin
    edge_raddr = mid;
    sum_raddr  = bin_q;
    unique case (state)
      S_DISP: begin
        edge_raddr = '0;
        sum_raddr  = BIN_W'(slot_q);
      end
      S_E0: begin
        edge_raddr = EDGE_AW'(BIN_COUNT);
      end
      S_EN: begin
        edge_raddr = EDGE_AW'(FIRST_MID);
      end
      S_SRCH: begin
        edge_raddr = EDGE_AW'(first_next + (count_next >> 1));
      end
      S_BIN: begin
        if (!below && !above) begin
          sum_raddr = sbin[BIN_W-1:0];
        end else if (below) begin
          sum_raddr = '0;
        end else begin
          sum_raddr = BIN_W'(BIN_COUNT - 1);
        end
      end
      default: begin
      end
    endcase
  end

  assign edge_we = (state == S_DISP) && (kind_q == K_LOAD_EDGE) && slot_edge_ok;
  assign sum_we  = (state == S_SUM) && op_add;

  hba_ram #(
    .WIDTH (DATA_W),
    .DEPTH (EDGE_DEPTH)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (EDGE_AW'(slot_q)),
    .wdata (x_q),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  // the write of one item lands before the next item can issue a read
  hba_ram #(
    .WIDTH (SUM_W),
    .DEPTH (BIN_COUNT)
  ) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (bin_q),
    .wdata (sum_new),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_of_range_mode <= MODE_IGNORE;
    end else if (cfg_write) begin
      out_of_range_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if ((state == S_DISP) && (kind_q == K_CLEAR_ALL)) begin
      valid <= '0;
    end else if (sum_we) begin
      valid[bin_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    mid   <= edge_raddr;
    bin_q <= sum_raddr;
    if (start && !busy) begin
      kind_q <= kind;
      x_q    <= sample_or_edge;
      slot_q <= slot_index;
      w_q    <= weight;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      bin_index <= '0;
      bin_sum   <= '0;
      status    <= ST_OK;
      first     <= '0;
      count     <= '0;
      sbin      <= '0;
      op_add    <= 1'b0;
      squeezed  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_DISP;
          end
        end
        S_DISP: begin
          op_add   <= (kind_q != K_READ_BIN);
          squeezed <= 1'b0;
          unique case (kind_q) inside
            K_LOAD_EDGE: begin
              done      <= 1'b1;
              bin_index <= IDX_W'(slot_q);
              bin_sum   <= '0;
              status    <= slot_edge_ok ? ST_OK : ST_ERROR;
              state     <= S_IDLE;
            end
            K_ADD_SAMPLE: begin
              state <= S_E0;
            end
            K_ADD_TO_BIN, K_READ_BIN: begin
              if (slot_bin_ok) begin
                state <= S_SUM;
              end else begin
                done      <= 1'b1;
                bin_index <= IDX_W'(slot_q);
                bin_sum   <= '0;
                status    <= ST_ERROR;
                state     <= S_IDLE;
              end
            end
            K_CLEAR_ALL: begin
              done      <= 1'b1;
              bin_index <= '0;
              bin_sum   <= '0;
              status    <= ST_OK;
              state     <= S_IDLE;
            end
            default: begin
              done      <= 1'b1;
              bin_index <= '0;
              bin_sum   <= '0;
              status    <= ST_ERROR;
              state     <= S_IDLE;
            end
          endcase
        end
        S_E0: begin
          if (x_q < $signed(edge_rdata)) begin
            sbin  <= '1;
            state <= S_BIN;
          end else begin
            state <= S_EN;
          end
        end
        S_EN: begin
          if (!(x_q < $signed(edge_rdata))) begin
            sbin  <= SB_W'(BIN_COUNT);
            state <= S_BIN;
          end else begin
            first <= '0;
            count <= CNT_W'(EDGE_DEPTH);
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          first <= first_next;
          count <= count_next;
          if (count_next == '0) begin
            sbin  <= $signed({1'b0, first_next}) - SB_W'(1);
            state <= S_BIN;
          end
        end
        S_BIN: begin
          if (!below && !above) begin
            state <= S_SUM;
          end else if (out_of_range_mode == MODE_IGNORE) begin
            done      <= 1'b1;
            bin_index <= IDX_W'(sbin);
            bin_sum   <= '0;
            status    <= ST_IGNORED;
            state     <= S_IDLE;
          end else if (out_of_range_mode == MODE_SQUEEZE) begin
            squeezed <= 1'b1;
            state    <= S_SUM;
          end else begin
            done      <= 1'b1;
            bin_index <= IDX_W'(sbin);
            bin_sum   <= '0;
            status    <= ST_ERROR;
            state     <= S_IDLE;
          end
        end
        S_SUM: begin
          done      <= 1'b1;
          bin_index <= IDX_W'(bin_q);
          bin_sum   <= op_add ? sum_new : sum_cur;
          status    <= squeezed ? ST_SQUEEZED : ST_OK;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a result always ends the command
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while still busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("transfer did not start a command");

  // the search window never empties while a read is still pending
  a_search_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH) |-> (count != '0))
    else $error("search step with empty window");

  a_ignored_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_IGNORED || status == ST_ERROR)) |-> (bin_sum == '0))
    else $error("ignored or failed command returned a sum");

endmodule

FILE: sim/tb_histogram_bin_accumulator.sv
// testbench for histogram_bin_accumulator: queued command driver, shadow predictor, result monitor
module tb_histogram_bin_accumulator;
  import hba_pkg::*;

  localparam logic [KIND_W-1:0] K_UNUSED_LO = 3'd5;
  localparam logic [KIND_W-1:0] K_UNUSED_HI = 3'd7;
  localparam logic [MODE_W-1:0] MODE_ERROR  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

  localparam longint S32_MIN = -(longint'(1) <<< 31);
  localparam longint S32_MAX = (longint'(1) <<< 31) - 1;
  localparam int SLOT_TOP       = (1 << SLOT_W) - 1;
  localparam int PHASE_ITEMS    = 62;
  localparam int SCRAMBLE_N     = 20;

  typedef enum logic [1:0] {ACT_COMMAND, ACT_SET_MODE, ACT_SETTLE} plan_action_t;

  typedef struct {
    plan_action_t             action;
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    logic [SLOT_W-1:0]        slot;
    logic signed [DATA_W-1:0] weight;
    logic [MODE_W-1:0]        mode;
    int                       gap;
  } plan_step_t;

  typedef struct packed {
    logic signed [IDX_W-1:0] idx;
    logic signed [SUM_W-1:0] sum;
    logic [STATUS_W-1:0]     st;
  } bin_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [KIND_W-1:0]        kind = '0;
  logic signed [DATA_W-1:0] sample_or_edge = '0;
  logic [SLOT_W-1:0]        slot_index = '0;
  logic signed [DATA_W-1:0] weight = '0;
  logic                     cfg_write = 1'b0;
  logic [MODE_W-1:0]        cfg_data = '0;
  logic                     busy;
  logic                     done;
  logic signed [IDX_W-1:0]  bin_index;
  logic signed [SUM_W-1:0]  bin_sum;
  logic [STATUS_W-1:0]      status;

  histogram_bin_accumulator uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .sample_or_edge (sample_or_edge),
    .slot_index     (slot_index),
    .weight         (weight),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .done           (done),
    .bin_index      (bin_index),
    .bin_sum        (bin_sum),
    .status         (status)
  );

  initial forever #6 clk = ~clk;

  // shadow of the block state
  logic signed [DATA_W-1:0] edge_copy [0:BIN_COUNT];
  logic signed [SUM_W-1:0]  sum_copy [0:BIN_COUNT-1] = '{default: '0};
  logic [MODE_W-1:0]        mode_copy = MODE_IGNORE;

  plan_step_t  command_plan [$];
  plan_step_t  on_port;
  bin_result_t bin_results_due [$];
  bin_result_t due;
  longint      plan_edge [0:BIN_COUNT];
  bit          no_idle = 1'b0;
  logic        hold_start;
  logic        cfg_pulse;
  int          fail_count = 0;
  int          transfers = 0;
  int          results_checked = 0;
  int          sample_status [4] = '{default: 0};

  function automatic int search_edges(input logic signed [DATA_W-1:0] x);
    int lo_pos, span, half, mid;
    lo_pos = 0;
    span = BIN_COUNT + 1;
    if (x < edge_copy[0]) return -1;
    if (x >= edge_copy[BIN_COUNT]) return BIN_COUNT;
    while (span > 0) begin
      half = span / 2;
      mid = lo_pos + half;
      if (!(x < edge_copy[mid])) begin
        lo_pos = mid + 1;
        span = span - half - 1;
      end else begin
        span = half;
      end
    end
    return lo_pos - 1;
  endfunction

  function automatic logic signed [SUM_W-1:0] bump_sum(input int b,
                                                       input logic signed [DATA_W-1:0] w);
    logic signed [SUM_W:0] t;
    t = sum_copy[b] + w;
    // clamp when the extra bit disagrees with the sign
    if (t[SUM_W] != t[SUM_W-1]) sum_copy[b] = {t[SUM_W], {(SUM_W-1){~t[SUM_W]}}};
    else sum_copy[b] = t[SUM_W-1:0];
    return sum_copy[b];
  endfunction

  function automatic bin_result_t predict_bin_update(input plan_step_t c);
    bin_result_t r;
    int b;
    r = '0;
    case (c.kind) inside
      K_LOAD_EDGE: begin
        r.idx = IDX_W'(c.slot);
        if (c.slot <= BIN_COUNT) edge_copy[c.slot] = c.value;
        else r.st = ST_ERROR;
      end
      K_ADD_SAMPLE: begin
        b = search_edges(c.value);
        if (b >= 0 && b < BIN_COUNT) begin
          r.sum = bump_sum(b, c.weight);
        end else if (mode_copy == MODE_IGNORE) begin
          r.st = ST_IGNORED;
        end else if (mode_copy == MODE_SQUEEZE) begin
          b = (b < 0) ? 0 : BIN_COUNT - 1;
          r.sum = bump_sum(b, c.weight);
          r.st = ST_SQUEEZED;
        end else begin
          r.st = ST_ERROR;
        end
        r.idx = IDX_W'(b);
        sample_status[r.st]++;
      end
      K_ADD_TO_BIN, K_READ_BIN: begin
        r.idx = IDX_W'(c.slot);
        if (c.slot >= BIN_COUNT) r.st = ST_ERROR;
        else if (c.kind == K_ADD_TO_BIN) r.sum = bump_sum(c.slot, c.weight);
        else r.sum = sum_copy[c.slot];
      end
      K_CLEAR_ALL: begin
        foreach (sum_copy[i]) sum_copy[i] = '0;
      end
      default: begin
        r.st = ST_ERROR;
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // stimulus helpers
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v < S32_MIN) return S32_MIN;
    if (v > S32_MAX) return S32_MAX;
    return v;
  endfunction

  function automatic longint rand32();
    return longint'($signed($urandom));
  endfunction

  function automatic longint pick_sample();
    int r, b;
    longint lo, hi;
    r = $urandom_range(99);
    b = $urandom_range(BIN_COUNT - 1);
    if (r < 50) begin
      lo = plan_edge[b];
      hi = plan_edge[b + 1] - 1;
      if (hi < lo) hi = lo;
      return lo + longint'($urandom) % (hi - lo + 1);
    end
    if (r < 65) return plan_edge[b];
    if (r < 75) return clamp32(plan_edge[b] - 1);
    if (r < 85) return clamp32(plan_edge[0] - 1 - longint'($urandom_range(1 << 20)));
    if (r < 95) return clamp32(plan_edge[BIN_COUNT] + longint'($urandom_range(1 << 20)));
    return rand32();
  endfunction

  function automatic longint pick_weight();
    int r;
    r = $urandom_range(99);
    if (r < 70) return rand32();
    if (r < 85) return longint'($urandom_range(1 << 16)) - (1 << 15);
    if (r < 93) return S32_MAX;
    return S32_MIN;
  endfunction

  function automatic int pick_bin_slot();
    if ($urandom_range(9) != 0) return $urandom_range(BIN_COUNT - 1);
    return $urandom_range(SLOT_TOP, BIN_COUNT);
  endfunction

  task automatic queue_command(input logic [KIND_W-1:0] k, input longint v, input int s,
                               input longint w);
    plan_step_t p;
    p.action = ACT_COMMAND;
    p.kind = k;
    p.value = DATA_W'(v);
    p.slot = SLOT_W'(s);
    p.weight = DATA_W'(w);
    p.mode = MODE_IGNORE;
    p.gap = pick_gap();
    command_plan.push_back(p);
  endtask

  task automatic queue_mode(input logic [MODE_W-1:0] m);
    plan_step_t p;
    p.action = ACT_SET_MODE;
    p.mode = m;
    p.gap = 0;
    command_plan.push_back(p);
  endtask

  // sender holds off until every outstanding result is back
  task automatic queue_settle();
    plan_step_t p;
    p.action = ACT_SETTLE;
    p.gap = 0;
    command_plan.push_back(p);
  endtask

  task automatic load_slot(input int s, input longint v);
    plan_edge[s] = v;
    queue_command(K_LOAD_EDGE, v, s, rand32());
  endtask

  // driver: one command on the ports at a time, config only when nothing is outstanding
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cfg_write <= 1'b0;
    end else begin
      hold_start = start && busy;
      cfg_pulse = 1'b0;
      if (start && !busy) begin
        bin_results_due.push_back(predict_bin_update(on_port));
        transfers++;
      end
      if (!hold_start && command_plan.size() > 0) begin
        if (command_plan[0].gap > 0) begin
          command_plan[0].gap = command_plan[0].gap - 1;
        end else begin
          case (command_plan[0].action)
            ACT_COMMAND: begin
              on_port = command_plan[0];
              command_plan.delete(0);
              kind <= on_port.kind;
              sample_or_edge <= on_port.value;
              slot_index <= on_port.slot;
              weight <= on_port.weight;
              hold_start = 1'b1;
            end
            ACT_SET_MODE: begin
              if (bin_results_due.size() == 0 && !done) begin
                mode_copy = command_plan[0].mode;
                cfg_data <= command_plan[0].mode;
                cfg_pulse = 1'b1;
                command_plan.delete(0);
              end
            end
            default: begin
              if (bin_results_due.size() == 0 && !done) command_plan.delete(0);
            end
          endcase
        end
      end
      start <= hold_start;
      cfg_write <= cfg_pulse;
    end
  end

  // monitor: every strobed result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (bin_results_due.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual %0d %0d %0d", $time,
                 bin_index, bin_sum, status);
      end else begin
        due = bin_results_due.pop_front();
        results_checked++;
        check_field("bin_index", due.idx, bin_index);
        check_field("bin_sum", due.sum, bin_sum);
        check_field("status", due.st, status);
      end
    end
  end

  initial begin : plan_and_finish
    int i, r, s;
    longint e, lo, hi;
    int scr_slot [SCRAMBLE_N];
    longint scr_old [SCRAMBLE_N];
    bit scrambled;
    logic [MODE_W-1:0] phase_modes [5];

    scrambled = 1'b0;
    phase_modes = '{MODE_SQUEEZE, MODE_ERROR, MODE_SPARE, MODE_IGNORE, MODE_SQUEEZE};

    // sums right after reset, bad bins and slots, unused kinds, clear
    queue_mode(MODE_IGNORE);
    queue_command(K_READ_BIN, 0, 0, 0);
    queue_command(K_READ_BIN, 0, BIN_COUNT - 1, 0);
    queue_command(K_READ_BIN, 0, BIN_COUNT, 0);
    queue_command(K_ADD_TO_BIN, 0, BIN_COUNT - 1, S32_MAX);
    queue_command(K_ADD_TO_BIN, 0, 0, S32_MIN);
    queue_command(K_ADD_TO_BIN, 0, 0, S32_MIN);
    queue_command(K_READ_BIN, 0, 0, 0);
    queue_command(K_ADD_TO_BIN, 0, SLOT_TOP, S32_MAX);
    queue_command(K_READ_BIN, 0, SLOT_TOP, 0);
    queue_command(K_LOAD_EDGE, S32_MAX, BIN_COUNT + 1, 0);
    queue_command(K_LOAD_EDGE, S32_MIN, SLOT_TOP, 0);
    for (int k = K_UNUSED_LO; k <= K_UNUSED_HI; k++) begin
      queue_command(KIND_W'(k), -1, SLOT_TOP, -1);
    end
    queue_command(K_CLEAR_ALL, 0, 0, 0);
    queue_command(K_READ_BIN, 0, BIN_COUNT - 1, 0);

    // ascending edge table with some repeated edges (empty bins)
    e = -(longint'(1) <<< 30) - longint'($urandom_range(1 << 20));
    for (s = 0; s <= BIN_COUNT; s++) begin
      if (s % 32 == 0) no_idle = ($urandom_range(2) == 0);
      load_slot(s, e);
      if ($urandom_range(4) != 0) e = clamp32(e + longint'($urandom_range(1 << 24)));
    end
    no_idle = 1'b0;
    queue_command(K_ADD_SAMPLE, S32_MIN, 0, S32_MAX);
    queue_command(K_ADD_SAMPLE, S32_MAX, SLOT_TOP, S32_MAX);
    queue_command(K_ADD_SAMPLE, plan_edge[0], 0, S32_MAX);
    queue_command(K_ADD_SAMPLE, plan_edge[BIN_COUNT], 0, S32_MAX);
    queue_command(K_ADD_SAMPLE, plan_edge[BIN_COUNT] - 1, 0, S32_MIN);
    queue_command(K_ADD_SAMPLE, plan_edge[BIN_COUNT / 2], 0, 1);

    foreach (phase_modes[p]) begin
      queue_settle();
      queue_mode(phase_modes[p]);
      if (phase_modes[p] == MODE_SPARE) begin
        // out-of-order edges for this whole phase
        for (i = 0; i < SCRAMBLE_N; i++) begin
          scr_slot[i] = $urandom_range(BIN_COUNT);
          scr_old[i] = plan_edge[scr_slot[i]];
          load_slot(scr_slot[i], rand32());
        end
        scrambled = 1'b1;
      end
      if (phase_modes[p] == MODE_IGNORE) begin
        load_slot(0, S32_MIN);
        load_slot(BIN_COUNT, S32_MAX);
      end
      queue_command(K_ADD_SAMPLE, clamp32(plan_edge[0] - 1), 0, pick_weight());
      queue_command(K_ADD_SAMPLE, plan_edge[BIN_COUNT], 0, pick_weight());
      queue_command(K_ADD_SAMPLE, S32_MAX, 0, pick_weight());
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 25 == 0) no_idle = ($urandom_range(3) == 0);
        r = $urandom_range(99);
        if (r < 55) begin
          queue_command(K_ADD_SAMPLE, pick_sample(), $urandom_range(SLOT_TOP), pick_weight());
        end else if (r < 68) begin
          queue_command(K_ADD_TO_BIN, rand32(), pick_bin_slot(), pick_weight());
        end else if (r < 82) begin
          queue_command(K_READ_BIN, rand32(), pick_bin_slot(), rand32());
        end else if (r < 85) begin
          queue_command(K_CLEAR_ALL, rand32(), $urandom_range(SLOT_TOP), rand32());
        end else if (r < 93) begin
          if ($urandom_range(9) == 0) begin
            queue_command(K_LOAD_EDGE, rand32(), $urandom_range(SLOT_TOP, BIN_COUNT + 1),
                          rand32());
          end else if (!scrambled) begin
            // move one edge without breaking the order
            s = $urandom_range(BIN_COUNT);
            lo = (s == 0) ? clamp32(plan_edge[0] - (1 << 20)) : plan_edge[s - 1];
            hi = (s == BIN_COUNT) ? clamp32(plan_edge[BIN_COUNT] + (1 << 20))
                                  : plan_edge[s + 1];
            if (hi < lo) hi = lo;
            load_slot(s, lo + longint'($urandom) % (hi - lo + 1));
          end
        end else if (r < 97) begin
          queue_command(K_UNUSED_LO + KIND_W'($urandom_range(K_UNUSED_HI - K_UNUSED_LO)),
                        rand32(), $urandom_range(SLOT_TOP), rand32());
        end else begin
          queue_settle();
        end
      end
      if (scrambled) begin
        for (i = SCRAMBLE_N - 1; i >= 0; i--) load_slot(scr_slot[i], scr_old[i]);
        scrambled = 1'b0;
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (command_plan.size() > 0 || start || bin_results_due.size() > 0) @(negedge clk);
    repeat (32) @(posedge clk);

    $display("%0d commands transferred, %0d results checked; edge tables sorted, scrambled",
             transfers, results_checked);
    $display("and at the 32-bit extremes; samples %0d binned, %0d ignored, %0d squeezed,",
             sample_status[ST_OK], sample_status[ST_IGNORED], sample_status[ST_SQUEEZED]);
    $display("%0d flagged", sample_status[ST_ERROR]);
    if (fail_count == 0 && bin_results_due.size() == 0) begin
      $display("tb_histogram_bin_accumulator passed");
    end else begin
      $display("tb_histogram_bin_accumulator failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_histogram_bin_accumulator failed");
    $finish;
  end

endmodule
